// ===== design/uapi_pkg.sv =====
// Shared types, constants and helper functions for the arc pose interpolator.
package uapi_pkg;

   localparam int SUBSTEPS = 5;
   localparam int J_W = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;

   localparam int POS_W  = 32;
   localparam int HEAD_W = 16;
   localparam int SPD_W  = 16;

   localparam int MAG_W  = 22;
   localparam int H_W    = 21;
   localparam int ANG_W  = 21;
   localparam int HSUM_W = 19;
   localparam int HWR_W  = 20;
   localparam int RED_W  = 19;
   localparam int Z_W    = 19;
   localparam int CS_W   = 32;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 3;

   localparam int NPROD_W = 49;
   localparam int U_W     = NPROD_W - 14;
   localparam int D_W     = 16;
   localparam int QW      = 23;
   localparam int LEN_W   = QW + 1;
   localparam int PROD_W  = LEN_W + CS_W;
   localparam int DX_W    = PROD_W - 30;

   localparam int FQ_DEPTH = 2;
   localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

   localparam int PI_Q16      = 205887;
   localparam int TWO_PI_Q16  = 411775;
   localparam int HALF_PI_Q16 = 102944;
   localparam int PI_Q13      = 25736;
   localparam int TWO_PI_Q13  = 51472;
   localparam int CORDIC_GAIN = 652032874;
   localparam longint ROUND_Q30 = 64'sd536870912;

   // pipeline stage numbers in the back end
   localparam int ST_H     = 3;
   localparam int ST_A_OUT = ST_H + CORDIC_LAT;
   localparam int ST_N     = ST_A_OUT + 1;
   localparam int ST_U     = ST_N + 1;
   localparam int ST_Q     = ST_U + QW;
   localparam int ST_LEN   = ST_Q + 1;
   localparam int ST_B_IN  = ST_LEN - CORDIC_LAT;
   localparam int ST_PROD  = ST_LEN + 1;
   localparam int ST_DX    = ST_PROD + 1;

   typedef struct packed {
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [HEAD_W-1:0] hd;
      logic signed [SPD_W-1:0]  v;
      logic signed [SPD_W-1:0]  w;
      logic                     str;
   } item_type;

   typedef struct packed {
      logic signed [SPD_W-1:0] v;
      logic signed [SPD_W-1:0] w;
      logic                    str;
      logic signed [H_W-1:0]   lstr;
      logic signed [H_W-1:0]   h;
      logic signed [ANG_W-1:0] phi;
   } arc_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [HSUM_W-1:0] head;
      logic                     last;
   } meta_type;

   // floor(x/5), exact for x below 2^22
   function automatic logic [19:0] div5(input logic [MAG_W-1:0] x);
      logic [43:0] p;
      p = 44'(x) * 44'd3355444;
      return p[43:24];
   endfunction

   function automatic logic signed [Z_W-1:0] atan_q16(input int i);
      case (i)
         0:       return Z_W'(51472);
         1:       return Z_W'(30385);
         2:       return Z_W'(16055);
         3:       return Z_W'(8150);
         4:       return Z_W'(4091);
         5:       return Z_W'(2047);
         6:       return Z_W'(1024);
         7:       return Z_W'(512);
         8:       return Z_W'(256);
         9:       return Z_W'(128);
         10:      return Z_W'(64);
         11:      return Z_W'(32);
         12:      return Z_W'(16);
         13:      return Z_W'(8);
         14:      return Z_W'(4);
         15:      return Z_W'(2);
         default: return Z_W'(0);
      endcase
   endfunction

endpackage

// ===== design/unicycle_arc_pose_interpolator.sv =====
// Top level of the unicycle constant-curvature arc pose interpolator.
//
// Each request transaction (start pose, linear and angular speed) yields SUBSTEPS
// response transactions, one sub-pose per clock unless rsp_stall holds the pipeline,
// the last one flagged by rsp_last_sub. A new request is taken while earlier ones
// are still in flight. The response path runs through the half-angle CORDIC
// pipeline (19 stages), the chord divider (one quotient bit per stage, 23 stages)
// and the final multiply, round and saturate stages. A two-entry queue buffers
// requests; a high rsp_stall while rsp_valid is high freezes the whole pipeline.
module unicycle_arc_pose_interpolator import uapi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_pose_x,
   input  logic signed [POS_W-1:0]  req_pose_y,
   input  logic signed [HEAD_W-1:0] req_pose_heading,
   input  logic signed [SPD_W-1:0]  req_lin_speed,
   input  logic signed [SPD_W-1:0]  req_ang_speed,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [POS_W-1:0]  rsp_out_x,
   output logic signed [POS_W-1:0]  rsp_out_y,
   output logic signed [HEAD_W-1:0] rsp_out_heading,
   output logic                     rsp_last_sub
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   uapi_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pose_x       (req_pose_x),
      .req_pose_y       (req_pose_y),
      .req_pose_heading (req_pose_heading),
      .req_lin_speed    (req_lin_speed),
      .req_ang_speed    (req_ang_speed),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   uapi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_heading (rsp_out_heading),
      .rsp_last_sub    (rsp_last_sub)
   );

endmodule

// ===== design/uapi_front.sv =====
// Front end: input transaction queue, classifies straight versus arc motion.
module uapi_front import uapi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_pose_x,
   input  logic signed [POS_W-1:0]  req_pose_y,
   input  logic signed [HEAD_W-1:0] req_pose_heading,
   input  logic signed [SPD_W-1:0]  req_lin_speed,
   input  logic signed [SPD_W-1:0]  req_ang_speed,
   output logic                     q_valid,
   output item_type                 q_item,
   input  logic                     q_pop
);

   item_type              fifo_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff;
   logic [FQ_PTR_W-1:0]   rd_ptr_ff;
   logic [FQ_CNT_W-1:0]   cnt_ff;
   logic                  push;
   logic                  pop;
   item_type              item_in;

   assign req_stall = (cnt_ff == FQ_CNT_W'(FQ_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = fifo_ff[rd_ptr_ff];

   always_comb begin
      item_in.px  = req_pose_x;
      item_in.py  = req_pose_y;
      item_in.hd  = req_pose_heading;
      item_in.v   = req_lin_speed;
      item_in.w   = req_ang_speed;
      item_in.str = (req_ang_speed == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== design/uapi_cordic.sv =====
// Pipelined CORDIC: range reduction, sixteen rotation stages, sign fix; sine and cosine in Q30.
module uapi_cordic import uapi_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [ANG_W-1:0] ang,
   output logic signed [CS_W-1:0]  sin_out,
   output logic signed [CS_W-1:0]  cos_out
);

   logic signed [RED_W-1:0] red_ff;
   logic signed [CS_W-1:0]  x_ff    [CORDIC_STEPS+1];
   logic signed [CS_W-1:0]  y_ff    [CORDIC_STEPS+1];
   logic signed [Z_W-1:0]   z_ff    [CORDIC_STEPS+1];
   logic                    flip_ff [CORDIC_STEPS+1];
   logic signed [CS_W-1:0]  sin_ff;
   logic signed [CS_W-1:0]  cos_ff;

   logic signed [ANG_W:0]   a;
   logic signed [ANG_W:0]   r0;
   logic signed [ANG_W:0]   r1;
   logic signed [ANG_W:0]   r2;
   logic signed [Z_W-1:0]   z_in;
   logic                    flip_in;

   always_comb begin
      a = (ANG_W+1)'(ang);
      if (a >= (ANG_W+1)'(TWO_PI_Q16)) begin
         r0 = a - (ANG_W+1)'(TWO_PI_Q16);
      end else if (a <= -(ANG_W+1)'(TWO_PI_Q16)) begin
         r0 = a + (ANG_W+1)'(TWO_PI_Q16);
      end else begin
         r0 = a;
      end
      r1 = (r0 >= (ANG_W+1)'(PI_Q16)) ? r0 - (ANG_W+1)'(TWO_PI_Q16) : r0;
      r2 = (r1 < -(ANG_W+1)'(PI_Q16)) ? r1 + (ANG_W+1)'(TWO_PI_Q16) : r1;
   end

   always_comb begin
      if (red_ff > RED_W'(HALF_PI_Q16)) begin
         z_in    = Z_W'(red_ff - RED_W'(PI_Q16));
         flip_in = 1'b1;
      end else if (red_ff < -RED_W'(HALF_PI_Q16)) begin
         z_in    = Z_W'(red_ff + RED_W'(PI_Q16));
         flip_in = 1'b1;
      end else begin
         z_in    = Z_W'(red_ff);
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff     <= RED_W'(r2);
         x_ff[0]    <= CS_W'(CORDIC_GAIN);
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         flip_ff[0] <= flip_in;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            flip_ff[i+1] <= flip_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q16(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q16(i);
            end
         end
         sin_ff <= flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
         cos_ff <= flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ===== design/uapi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, sign carried alongside.
module uapi_div import uapi_pkg::*; (
   input  logic           clock,
   input  logic           en,
   input  logic [U_W-1:0] num,
   input  logic [D_W-1:0] den,
   input  logic           neg_in,
   output logic [QW-1:0]  quo,
   output logic           neg_out
);

   localparam int T_W = D_W + QW;

   logic [U_W-1:0] rem_ff [QW];
   logic [QW-1:0]  quo_ff [QW];
   logic [D_W-1:0] den_ff [QW];
   logic           neg_ff [QW];

   logic [U_W-1:0] rem_src [QW];
   logic [QW-1:0]  quo_src [QW];
   logic [D_W-1:0] den_src [QW];
   logic           neg_src [QW];
   logic [T_W-1:0] shd     [QW];
   logic           ge      [QW];

   always_comb begin
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            rem_src[k] = num;
            quo_src[k] = '0;
            den_src[k] = den;
            neg_src[k] = neg_in;
         end else begin
            rem_src[k] = rem_ff[k-1];
            quo_src[k] = quo_ff[k-1];
            den_src[k] = den_ff[k-1];
            neg_src[k] = neg_ff[k-1];
         end
         shd[k] = T_W'(den_src[k]) << (QW - 1 - k);
         ge[k]  = (T_W'(rem_src[k]) >= shd[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            den_ff[k] <= den_src[k];
            neg_ff[k] <= neg_src[k];
            if (ge[k]) begin
               rem_ff[k] <= U_W'(T_W'(rem_src[k]) - shd[k]);
               quo_ff[k] <= quo_src[k] | (QW'(1) << (QW - 1 - k));
            end else begin
               rem_ff[k] <= rem_src[k];
               quo_ff[k] <= quo_src[k];
            end
         end
      end
   end

   assign quo     = quo_ff[QW-1];
   assign neg_out = neg_ff[QW-1];

endmodule

// ===== design/uapi_back.sv =====
// Back end: sub-step sequencer and the arc geometry pipeline with its result register.
module uapi_back import uapi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  item_type                 q_item,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [POS_W-1:0]  rsp_out_x,
   output logic signed [POS_W-1:0]  rsp_out_y,
   output logic signed [HEAD_W-1:0] rsp_out_heading,
   output logic                     rsp_last_sub
);

   logic en;

   logic                     vld_ff [ST_DX+1];
   logic                     rsp_valid_ff;
   logic [J_W-1:0]           j_ff;

   item_type                 s0_item_ff;
   logic [J_W-1:0]           s0_j_ff;
   logic                     s0_last_ff;

   item_type                 s1_item_ff;
   logic                     s1_last_ff;
   logic [MAG_W-1:0]         s1_hm_ff;
   logic [MAG_W-1:0]         s1_dm_ff;
   logic [MAG_W-1:0]         s1_lm_ff;
   logic                     s1_hneg_ff;
   logic                     s1_dneg_ff;
   logic                     s1_lneg_ff;

   item_type                 s2_item_ff;
   logic                     s2_last_ff;
   logic signed [H_W-1:0]    s2_h_ff;
   logic signed [H_W-1:0]    s2_d13_ff;
   logic signed [H_W-1:0]    s2_lstr_ff;

   arc_type                  arc_ff  [ST_H:ST_LEN];
   meta_type                 meta_ff [ST_H:ST_DX];

   logic signed [CS_W-1:0]   sin_a;
   logic signed [CS_W-1:0]   sin_b;
   logic signed [CS_W-1:0]   cos_b;

   logic signed [NPROD_W-1:0] nprod_ff;
   logic [U_W-1:0]            u_ff;
   logic [D_W-1:0]            den_ff;
   logic                      qneg_ff;
   logic [QW-1:0]             quo;
   logic                      quo_neg;
   logic signed [LEN_W-1:0]   len_ff;
   logic signed [PROD_W-1:0]  prodx_ff;
   logic signed [PROD_W-1:0]  prody_ff;
   logic signed [DX_W-1:0]    dx_ff;
   logic signed [DX_W-1:0]    dy_ff;

   logic signed [POS_W-1:0]   out_x_ff;
   logic signed [POS_W-1:0]   out_y_ff;
   logic signed [HEAD_W-1:0]  out_head_ff;
   logic                      out_last_ff;

   logic                      issue_last;
   logic signed [J_W:0]       js;
   logic signed [20:0]        wj;
   logic signed [22:0]        wj4;
   logic signed [23:0]        vj8;
   logic [22:0]               wj4_abs;
   logic [20:0]               wj_abs;
   logic [23:0]               vj8_abs;
   logic [NPROD_W-1:0]        nabs;
   logic [D_W-1:0]            wabs;
   logic signed [LEN_W-1:0]   qs;
   logic signed [HWR_W-1:0]   hw0;
   logic signed [HWR_W-1:0]   hw1;
   logic signed [HWR_W-1:0]   hw2;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W-1:0] p,
                                                       input logic signed [DX_W-1:0] d);
      logic signed [POS_W:0] s;
      s = (POS_W+1)'(p) + (POS_W+1)'(d);
      if (s[POS_W] != s[POS_W-1]) begin
         return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
      return s[POS_W-1:0];
   endfunction

   assign en         = !rsp_valid_ff || !rsp_stall;
   assign issue_last = (j_ff == J_W'(SUBSTEPS - 1));
   assign q_pop      = en && q_valid && issue_last;

   // sub-step products and magnitudes for the rounded divides by five
   always_comb begin
      js      = signed'({1'b0, s0_j_ff});
      wj      = 21'(s0_item_ff.w) * 21'(js);
      wj4     = 23'(wj) <<< 2;
      vj8     = (24'(s0_item_ff.v) * 24'(js)) <<< 3;
      wj4_abs = wj4[22] ? 23'(-wj4) : 23'(wj4);
      wj_abs  = wj[20] ? 21'(-wj) : 21'(wj);
      vj8_abs = vj8[23] ? 24'(-vj8) : 24'(vj8);
   end

   always_comb begin
      nabs = nprod_ff[NPROD_W-1] ? NPROD_W'(-nprod_ff) : NPROD_W'(nprod_ff);
      wabs = arc_ff[ST_N].w[SPD_W-1] ? D_W'(-arc_ff[ST_N].w) : D_W'(arc_ff[ST_N].w);
      qs   = signed'({1'b0, quo});
   end

   always_comb begin
      hw0 = HWR_W'(meta_ff[ST_DX].head);
      hw1 = (hw0 >= HWR_W'(PI_Q13)) ? hw0 - HWR_W'(TWO_PI_Q13) : hw0;
      hw2 = (hw1 < -HWR_W'(PI_Q13)) ? hw1 + HWR_W'(TWO_PI_Q13) : hw1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t <= ST_DX; t++) begin
            vld_ff[t] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= q_valid;
         for (int t = 1; t <= ST_DX; t++) begin
            vld_ff[t] <= vld_ff[t-1];
         end
         rsp_valid_ff <= vld_ff[ST_DX];
         if (q_valid) begin
            j_ff <= issue_last ? '0 : j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_item_ff <= q_item;
         s0_j_ff    <= j_ff;
         s0_last_ff <= issue_last;

         s1_item_ff <= s0_item_ff;
         s1_last_ff <= s0_last_ff;
         s1_hm_ff   <= MAG_W'(wj4_abs) + MAG_W'(2);
         s1_hneg_ff <= wj4[22];
         s1_dm_ff   <= MAG_W'(wj_abs) + MAG_W'(2);
         s1_dneg_ff <= wj[20];
         s1_lm_ff   <= MAG_W'(vj8_abs) + MAG_W'(2);
         s1_lneg_ff <= vj8[23];

         s2_item_ff <= s1_item_ff;
         s2_last_ff <= s1_last_ff;
         s2_h_ff    <= s1_hneg_ff ? -H_W'(div5(s1_hm_ff)) : H_W'(div5(s1_hm_ff));
         s2_d13_ff  <= s1_dneg_ff ? -H_W'(div5(s1_dm_ff)) : H_W'(div5(s1_dm_ff));
         s2_lstr_ff <= s1_lneg_ff ? -H_W'(div5(s1_lm_ff)) : H_W'(div5(s1_lm_ff));

         arc_ff[ST_H].v    <= s2_item_ff.v;
         arc_ff[ST_H].w    <= s2_item_ff.w;
         arc_ff[ST_H].str  <= s2_item_ff.str;
         arc_ff[ST_H].lstr <= s2_lstr_ff;
         arc_ff[ST_H].h    <= s2_h_ff;
         arc_ff[ST_H].phi  <= (ANG_W'(s2_item_ff.hd) <<< 3) + ANG_W'(s2_h_ff);
         for (int t = ST_H + 1; t <= ST_LEN; t++) begin
            arc_ff[t] <= arc_ff[t-1];
         end

         meta_ff[ST_H].px   <= s2_item_ff.px;
         meta_ff[ST_H].py   <= s2_item_ff.py;
         meta_ff[ST_H].head <= HSUM_W'(s2_item_ff.hd) + HSUM_W'(s2_d13_ff);
         meta_ff[ST_H].last <= s2_last_ff;
         for (int t = ST_H + 1; t <= ST_DX; t++) begin
            meta_ff[t] <= meta_ff[t-1];
         end

         nprod_ff <= (NPROD_W'(arc_ff[ST_A_OUT].v) * NPROD_W'(sin_a)) <<< 1;

         u_ff    <= U_W'((nabs + (NPROD_W'(wabs) << 13)) >> 14);
         den_ff  <= wabs;
         qneg_ff <= nprod_ff[NPROD_W-1] ^ arc_ff[ST_N].w[SPD_W-1];

         if (arc_ff[ST_Q].str) begin
            len_ff <= LEN_W'(arc_ff[ST_Q].lstr);
         end else begin
            len_ff <= quo_neg ? -qs : qs;
         end

         prodx_ff <= PROD_W'(len_ff) * PROD_W'(cos_b);
         prody_ff <= PROD_W'(len_ff) * PROD_W'(sin_b);

         dx_ff <= DX_W'((prodx_ff + PROD_W'(ROUND_Q30)) >>> 30);
         dy_ff <= DX_W'((prody_ff + PROD_W'(ROUND_Q30)) >>> 30);

         out_x_ff    <= sat_pos(meta_ff[ST_DX].px, dx_ff);
         out_y_ff    <= sat_pos(meta_ff[ST_DX].py, dy_ff);
         out_last_ff <= meta_ff[ST_DX].last;
         if (hw2 > HWR_W'(32767)) begin
            out_head_ff <= 16'sh7fff;
         end else if (hw2 < -HWR_W'(32768)) begin
            out_head_ff <= 16'sh8000;
         end else begin
            out_head_ff <= HEAD_W'(hw2);
         end
      end
   end

   uapi_cordic u_cordic_half (
      .clock   (clock),
      .en      (en),
      .ang     (ANG_W'(arc_ff[ST_H].h)),
      .sin_out (sin_a),
      .cos_out ()
   );

   uapi_cordic u_cordic_dir (
      .clock   (clock),
      .en      (en),
      .ang     (arc_ff[ST_B_IN].phi),
      .sin_out (sin_b),
      .cos_out (cos_b)
   );

   uapi_div u_div (
      .clock   (clock),
      .en      (en),
      .num     (u_ff),
      .den     (den_ff),
      .neg_in  (qneg_ff),
      .quo     (quo),
      .neg_out (quo_neg)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_out_heading = out_head_ff;
   assign rsp_last_sub    = out_last_ff;

endmodule
